[sv/itoa_fmt_pkg.sv]
// Shared types, constants and helpers for the integer-to-ASCII field formatter.
// Used by integer_to_ascii_field_formatter; no other dependencies.
package itoa_fmt_pkg;

    // Field and digit sizing
    localparam int MAX_DIGITS = 32;
    localparam int WORD_W     = 32;
    localparam int WIDTH_W    = 6;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 8;

    localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(MAX_DIGITS < 32 ? MAX_DIGITS : 32);
    localparam logic [WORD_W-1:0]  SIGN_BIT  = 32'h8000_0000;

    // Reciprocal of ten for 32-bit words: q = (w * RECIP10) >> 35
    localparam logic [WORD_W-1:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int                RECIP10_SH = 35;

    // Radix codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // ASCII codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_LOWA  = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;

    // Conversion request
    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic [1:0]         radix_select;
        logic               is_signed;
        logic               upper_case;
        logic [WIDTH_W-1:0] field_width;
        logic               zero_fill;
    } fmt_arg_t;

    // One output character
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
    } fmt_sym_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIGIT,
        ST_SIGN,
        ST_FILL,
        ST_EMIT
    } fmt_state_t;

    // Digit value to ASCII
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
                                                         input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? ASCII_UPA : ASCII_LOWA;
        if (d > 4'd9)
            digit_to_ascii = base + CHAR_W'(d) - CHAR_W'(10);
        else
            digit_to_ascii = ASCII_ZERO + CHAR_W'(d);
    endfunction

endpackage

[sv/integer_to_ascii_field_formatter.sv]
// Integer-to-ASCII field formatter: converts one 32-bit word into a padded
// ASCII integer field. Depends on itoa_fmt_pkg.
//
// Usage:
//   arg channel (arg_valid / arg_stall / arg) takes one conversion request:
//   word, radix, signedness, hex case, field width and fill choice. arg_stall
//   is high from acceptance until the last character is loaded into the
//   output register.
//   sym channel (sym_valid / sym_stall / sym) returns the characters of each
//   request, most significant first: optional '-', fill, then digits; the
//   final one carries last_char.
// Timing:
//   Digits come out of one shared divide-by-radix unit, least significant
//   first, into a 32-entry digit buffer: one digit per cycle for radix 2/8/16;
//   for radix 10 each digit takes a reciprocal multiply, then the remainder.
//   Emission then gives one character per cycle unless the receiver stalls.
//   An item has at most 33 characters.
// Stall: a stalled character holds in the output register and the sequencer
//   waits; nothing is dropped. Reset clears the sequencer and the output
//   valid; the block is ready right after reset.
module integer_to_ascii_field_formatter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   arg_valid,
    output logic                   arg_stall,
    input  itoa_fmt_pkg::fmt_arg_t arg,
    output logic                   sym_valid,
    input  logic                   sym_stall,
    output itoa_fmt_pkg::fmt_sym_t sym
);
    import itoa_fmt_pkg::*;

    fmt_state_t          state_reg, state_next;
    logic [WORD_W-1:0]   word_reg, word_next;
    logic [2*WORD_W-1:0] prod_reg, prod_next;
    logic [1:0]          radix_reg, radix_next;
    logic                upper_reg, upper_next;
    logic                neg_reg, neg_next;
    logic                pad_zero_reg, pad_zero_next;
    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [WIDTH_W-1:0]  nd_reg, nd_next;
    logic [WIDTH_W-1:0]  fill_reg, fill_next;
    logic [DIGIT_W-1:0]  digits_reg [MAX_DIGITS];
    logic                out_valid_reg, out_valid_next;
    fmt_sym_t            out_reg, out_next;

    logic                accept;
    logic                load;
    logic [WORD_W-1:0]   quot;
    logic [DIGIT_W-1:0]  dig;
    logic [WORD_W-1:0]   q10;
    logic [WIDTH_W-1:0]  nd_inc;
    logic                conv_done;
    logic [WIDTH_W-1:0]  fill_calc;
    logic [WIDTH_W-1:0]  rd_idx;
    logic [DIGIT_W-1:0]  rd_digit;

    assign arg_stall = (state_reg != ST_IDLE);
    assign accept    = arg_valid && !arg_stall;
    assign load      = !out_valid_reg || !sym_stall;
    assign sym_valid = out_valid_reg;
    assign sym       = out_reg;

    // Shared divide-by-radix unit
    assign q10 = {quot[WORD_W-4:0], 3'b000} + {quot[WORD_W-2:0], 1'b0};
    always_comb
    begin
        case (radix_reg)
            RADIX_BIN:
            begin
                quot = word_reg >> 1;
                dig  = {3'b000, word_reg[0]};
            end
            RADIX_OCT:
            begin
                quot = word_reg >> 3;
                dig  = {1'b0, word_reg[2:0]};
            end
            RADIX_HEX:
            begin
                quot = word_reg >> 4;
                dig  = word_reg[3:0];
            end
            default:
            begin
                quot = WORD_W'(prod_reg >> RECIP10_SH);
                dig  = DIGIT_W'(word_reg - q10);
            end
        endcase
    end

    // Digit count and fill after this digit
    assign nd_inc    = nd_reg + WIDTH_W'(1);
    assign conv_done = (quot == '0) || (nd_inc == WIDTH_W'(MAX_DIGITS));
    assign fill_calc = (width_reg > nd_inc) ? (width_reg - nd_inc) : '0;

    // Digit buffer read, most significant stored digit first
    assign rd_idx   = nd_reg - WIDTH_W'(1);
    assign rd_digit = digits_reg[rd_idx[4:0]];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (arg.radix_select == RADIX_DEC) ? ST_MUL : ST_DIGIT;
            end
            ST_MUL:
                state_next = ST_DIGIT;
            ST_DIGIT:
            begin
                if (conv_done)
                begin
                    if (neg_reg)
                        state_next = ST_SIGN;
                    else if (fill_calc != '0)
                        state_next = ST_FILL;
                    else
                        state_next = ST_EMIT;
                end
                else if (radix_reg == RADIX_DEC)
                    state_next = ST_MUL;
            end
            ST_SIGN:
            begin
                if (load)
                    state_next = (fill_reg != '0) ? ST_FILL : ST_EMIT;
            end
            ST_FILL:
            begin
                if (load && fill_reg == WIDTH_W'(1))
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load && nd_reg == WIDTH_W'(1))
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Datapath and output next values
    always_comb
    begin
        word_next      = word_reg;
        prod_next      = prod_reg;
        radix_next     = radix_reg;
        upper_next     = upper_reg;
        neg_next       = neg_reg;
        pad_zero_next  = pad_zero_reg;
        width_next     = width_reg;
        nd_next        = nd_reg;
        fill_next      = fill_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && sym_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next      = arg.is_signed && ((arg.value & SIGN_BIT) != '0);
                    word_next     = neg_next ? (~arg.value + WORD_W'(1)) : arg.value;
                    radix_next    = arg.radix_select;
                    upper_next    = arg.upper_case;
                    pad_zero_next = arg.zero_fill;
                    width_next    = (arg.field_width > WIDTH_CAP) ? WIDTH_CAP : arg.field_width;
                    nd_next       = '0;
                end
            end
            ST_MUL:
                prod_next = (2*WORD_W)'(word_reg) * (2*WORD_W)'(RECIP10);
            ST_DIGIT:
            begin
                word_next = quot;
                nd_next   = nd_inc;
                if (conv_done)
                    fill_next = fill_calc;
            end
            ST_SIGN:
            begin
                if (load)
                begin
                    out_next.out_char  = ASCII_MINUS;
                    out_next.last_char = 1'b0;
                    out_valid_next     = 1'b1;
                end
            end
            ST_FILL:
            begin
                if (load)
                begin
                    out_next.out_char  = pad_zero_reg ? ASCII_ZERO : ASCII_SPACE;
                    out_next.last_char = 1'b0;
                    out_valid_next     = 1'b1;
                    fill_next          = fill_reg - WIDTH_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    out_next.out_char  = digit_to_ascii(rd_digit, upper_reg);
                    out_next.last_char = (nd_reg == WIDTH_W'(1));
                    out_valid_next     = 1'b1;
                    nd_next            = rd_idx;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        prod_reg     <= prod_next;
        radix_reg    <= radix_next;
        upper_reg    <= upper_next;
        neg_reg      <= neg_next;
        pad_zero_reg <= pad_zero_next;
        width_reg    <= width_next;
        nd_reg       <= nd_next;
        fill_reg     <= fill_next;
        out_reg      <= out_next;
    end

    // Digit buffer, written least significant first
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DIGIT)
            digits_reg[nd_reg[4:0]] <= dig;
    end

endmodule

[sim/ascii_field_checker.sv]
// Scoreboard for the integer-to-ASCII field formatter: predicts the characters of each
// accepted request and compares them against the character stream.
// Depends on itoa_fmt_pkg for the channel structs and ASCII constants.
module ascii_field_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   arg_valid,
    input  logic                   arg_stall,
    input  itoa_fmt_pkg::fmt_arg_t arg,
    input  logic                   sym_valid,
    input  logic                   sym_stall,
    input  itoa_fmt_pkg::fmt_sym_t sym,
    output int                     mismatch_count,
    output int                     chars_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_fmt_pkg::*;

    // Characters still owed by the block, oldest first
    fmt_sym_t expected_chars[$];

    // One line per mismatch
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        fmt_sym_t c;
        c.out_char  = ch;
        c.last_char = is_last;
        expected_chars.push_back(c);
    endtask

    // Build the field for one request: optional '-', fill, then digits MSB first
    task automatic format_field(input fmt_arg_t req);
        logic [WORD_W-1:0]  word;
        logic [WORD_W-1:0]  radix;
        logic [WORD_W-1:0]  d;
        logic [WIDTH_W-1:0] width;
        logic [CHAR_W-1:0]  pad;
        logic [CHAR_W-1:0]  digit_chars [MAX_DIGITS];
        logic               negative;
        int                 nd;
        int                 fill;
        int                 total;
        int                 k;
        width = (req.field_width > WIDTH_CAP) ? WIDTH_CAP : req.field_width;
        pad   = req.zero_fill ? ASCII_ZERO : ASCII_SPACE;
        case (req.radix_select)
            RADIX_BIN: radix = 32'd2;
            RADIX_OCT: radix = 32'd8;
            RADIX_DEC: radix = 32'd10;
            default:   radix = 32'd16;
        endcase

        // sign applies to every radix; most negative word keeps full magnitude
        word     = req.value;
        negative = req.is_signed && ((word & SIGN_BIT) != 0);
        if (negative)
            word = ~word + 32'd1;

        // digits, least significant first
        nd = 0;
        do begin
            d = word % radix;
            if (d > 32'd9)
                digit_chars[nd] = (req.upper_case ? ASCII_UPA : ASCII_LOWA) + CHAR_W'(d - 32'd10);
            else
                digit_chars[nd] = ASCII_ZERO + CHAR_W'(d);
            nd++;
            word = word / radix;
        end while (word != 0 && nd < MAX_DIGITS);

        fill  = (int'(width) > nd) ? int'(width) - nd : 0;
        total = int'(negative) + fill + nd;
        k     = 0;
        if (negative)
        begin
            k++;
            push_char(ASCII_MINUS, k == total);
        end
        repeat (fill)
        begin
            k++;
            push_char(pad, k == total);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            k++;
            push_char(digit_chars[i], k == total);
        end
    endtask

    // Compare accepted characters first, then queue the prediction for a new request
    always @(posedge clk)
    begin : watch
        fmt_sym_t want;
        if (rst_n)
        begin
            if (sym_valid && !sym_stall)
            begin
                if (expected_chars.size() == 0)
                    report_mismatch($sformatf("unexpected char 0x%02h last=%0b",
                                              sym.out_char, sym.last_char));
                else
                begin
                    want = expected_chars.pop_front();
                    if (sym.out_char !== want.out_char)
                        report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                                  sym.out_char, want.out_char));
                    if (sym.last_char !== want.last_char)
                        report_mismatch($sformatf("last_char %0b, expected %0b on 0x%02h",
                                                  sym.last_char, want.last_char, want.out_char));
                end
            end
            if (arg_valid && !arg_stall)
                format_field(arg);
            chars_pending <= expected_chars.size();
        end
    end

endmodule

[sim/tb_integer_to_ascii_field_formatter.sv]
// Testbench top for integer_to_ascii_field_formatter: clock, reset, request stimulus
// and receiver stalls. Depends on itoa_fmt_pkg, the block and ascii_field_checker.
module tb_integer_to_ascii_field_formatter;
    timeunit 1ns;
    timeprecision 1ps;

    import itoa_fmt_pkg::*;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_mode_t;

    localparam int RANDOM_REQUESTS = 300;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        arg_valid = 1'b0;
    logic        arg_stall;
    fmt_arg_t    arg       = '0;
    logic        sym_valid;
    logic        sym_stall = 1'b0;
    fmt_sym_t    sym;
    int          mismatch_count;
    int          chars_pending;

    stall_mode_t stall_mode      = STALL_NONE;
    int          stall_mode_left = 0;
    int          burst_left      = 0;
    fmt_arg_t    corner_cases[$];

    always #1 clk = ~clk;

    integer_to_ascii_field_formatter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .arg_valid (arg_valid),
        .arg_stall (arg_stall),
        .arg       (arg),
        .sym_valid (sym_valid),
        .sym_stall (sym_stall),
        .sym       (sym)
    );

    ascii_field_checker field_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .arg_valid      (arg_valid),
        .arg_stall      (arg_stall),
        .arg            (arg),
        .sym_valid      (sym_valid),
        .sym_stall      (sym_stall),
        .sym            (sym),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    // Receiver: stall mode is redrawn when its countdown runs out, including stall-free stretches
    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      <= stall_mode_t'(2'($urandom_range(0, 3)));
            stall_mode_left <= $urandom_range(20, 200);
        end
        else
            stall_mode_left <= stall_mode_left - 1;
        case (stall_mode)
            STALL_NONE:   sym_stall <= 1'b0;
            STALL_LIGHT:  sym_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:  sym_stall <= ($urandom_range(0, 3) != 0);
            default:      sym_stall <= ~sym_stall;
        endcase
    end

    function automatic fmt_arg_t make_request(input logic [WORD_W-1:0] value,
                                              input logic [1:0] radix, input logic sgn,
                                              input logic upper, input logic [WIDTH_W-1:0] width,
                                              input logic zero);
        fmt_arg_t r;
        r.value        = value;
        r.radix_select = radix;
        r.is_signed    = sgn;
        r.upper_case   = upper;
        r.field_width  = width;
        r.zero_fill    = zero;
        return r;
    endfunction

    // Random request: values lean toward small numbers and the ends of the word
    function automatic fmt_arg_t random_request();
        logic [WORD_W-1:0]  v;
        logic [WIDTH_W-1:0] w;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 20);
            1:       v = $urandom;
            2:       v = SIGN_BIT - 32'd4 + $urandom_range(0, 8);
            3:       v = 32'hFFFF_FFFF - $urandom_range(0, 20);
            4:       v = 32'd1 << $urandom_range(0, 31);
            default: v = $urandom_range(0, 1000000);
        endcase
        if ($urandom_range(0, 3) == 0)
            w = WIDTH_W'($urandom_range(0, 63));
        else
            w = WIDTH_W'($urandom_range(0, 12));
        return make_request(v, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                            w, 1'($urandom));
    endfunction

    // Sender: bursts of back-to-back requests separated by idle gaps
    task automatic send_request(input fmt_arg_t req);
        if (burst_left == 0)
        begin
            arg_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(1, 4);
        end
        burst_left--;
        arg       <= req;
        arg_valid <= 1'b1;
        @(posedge clk);
        while (arg_stall) @(posedge clk);
    endtask

    initial
    begin
        // corner cases: zero, full words, most negative, sign in every radix, widths
        corner_cases.push_back(make_request(32'd0,          RADIX_DEC, 1'b0, 1'b0, 6'd0,  1'b0));
        corner_cases.push_back(make_request(32'd0,          RADIX_HEX, 1'b0, 1'b0, 6'd5,  1'b1));
        corner_cases.push_back(make_request(32'hFFFF_FFFF, RADIX_BIN, 1'b0, 1'b0, 6'd0,  1'b0));
        corner_cases.push_back(make_request(32'hFFFF_FFFF, RADIX_OCT, 1'b0, 1'b0, 6'd0,  1'b0));
        corner_cases.push_back(make_request(32'hFFFF_FFFF, RADIX_DEC, 1'b0, 1'b0, 6'd32, 1'b0));
        corner_cases.push_back(make_request(32'hFFFF_FFFF, RADIX_HEX, 1'b0, 1'b0, 6'd0,  1'b0));
        corner_cases.push_back(make_request(32'hFFFF_FFFF, RADIX_HEX, 1'b0, 1'b1, 6'd0,  1'b0));
        corner_cases.push_back(make_request(32'h8000_0000, RADIX_DEC, 1'b1, 1'b0, 6'd0,  1'b0));
        corner_cases.push_back(make_request(32'h8000_0000, RADIX_BIN, 1'b1, 1'b0, 6'd32, 1'b1));
        corner_cases.push_back(make_request(32'hFFFF_FFFB, RADIX_DEC, 1'b1, 1'b0, 6'd5,  1'b1));
        corner_cases.push_back(make_request(32'hFFFF_FFFB, RADIX_DEC, 1'b1, 1'b0, 6'd5,  1'b0));
        corner_cases.push_back(make_request(32'hFFFF_FFFF, RADIX_HEX, 1'b1, 1'b1, 6'd8,  1'b1));
        corner_cases.push_back(make_request(32'hFFFF_FFF8, RADIX_OCT, 1'b1, 1'b0, 6'd3,  1'b0));
        corner_cases.push_back(make_request(32'hFFFF_FFFD, RADIX_BIN, 1'b1, 1'b0, 6'd4,  1'b1));
        corner_cases.push_back(make_request(32'h7FFF_FFFF, RADIX_DEC, 1'b1, 1'b0, 6'd12, 1'b0));
        corner_cases.push_back(make_request(32'hABCD_EF01, RADIX_HEX, 1'b0, 1'b1, 6'd63, 1'b1));
        corner_cases.push_back(make_request(32'hABCD_EF01, RADIX_HEX, 1'b0, 1'b0, 6'd33, 1'b0));
        corner_cases.push_back(make_request(32'd12345,      RADIX_DEC, 1'b0, 1'b0, 6'd2,  1'b1));
        corner_cases.push_back(make_request(32'h8000_0000, RADIX_DEC, 1'b0, 1'b0, 6'd0,  1'b0));
        corner_cases.push_back(make_request(32'd1,          RADIX_BIN, 1'b0, 1'b0, 6'd32, 1'b1));
        corner_cases.push_back(make_request(32'd0,          RADIX_DEC, 1'b1, 1'b0, 6'd63, 1'b0));
        corner_cases.push_back(make_request(32'h5555_5555, RADIX_OCT, 1'b0, 1'b1, 6'd16, 1'b1));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (corner_cases[i])
            send_request(corner_cases[i]);
        repeat (RANDOM_REQUESTS)
            send_request(random_request());
        arg_valid <= 1'b0;

        // drain, then keep the clock running to catch anything stray
        do @(posedge clk); while (chars_pending != 0);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #1_500_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
